>>> rtl/core/mbps_pkg.sv
// Shared constants, register codes and types for the masked byte pattern scanner.
package mbps_pkg;

	localparam int PATTERN_MAX = 16;
	localparam int PAT_CAP     = (PATTERN_MAX < 16) ? PATTERN_MAX : 16;
	localparam int LEN_IDX_W   = (PAT_CAP > 1) ? $clog2(PAT_CAP) : 1;
	localparam int LEN_W       = 5;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int ADDR_W      = 64;
	localparam int COUNT_W     = 32;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = 2;
	localparam int FIFO_LVL_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_ADDRESS   = 3'd0,
		REG_PATTERN_LOW    = 3'd1,
		REG_PATTERN_HIGH   = 3'd2,
		REG_CARE_MASK      = 3'd3,
		REG_PATTERN_LENGTH = 3'd4
	} cfg_reg_t;

	// Control for one step of the cell row.
	typedef struct packed {
		logic en;     // shift a byte through the row
		logic first;  // byte opens a new region
	} step_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] addr;
	} result_t;

endpackage

>>> rtl/core/mbps_cell.sv
// One cell of the scan row: holds whether a pattern prefix ends at the latest byte.
module mbps_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       prev,
	input  logic       care,
	input  logic [7:0] data_byte,
	input  logic [7:0] pat_byte,
	output logic       hit_d,
	output logic       hit_q
);

	assign hit_d = prev & (~care | (data_byte == pat_byte));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (en) begin
			hit_q <= hit_d;
		end
	end

endmodule

>>> rtl/core/mbps_chain.sv
// Row of scan cells; each cell extends the prefix match of its left neighbor.
module mbps_chain (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mbps_pkg::step_t                        step,
	input  logic [7:0]                             data_byte,
	input  logic [8*mbps_pkg::PAT_CAP-1:0]         pattern,
	input  logic [mbps_pkg::PAT_CAP-1:0]           care,
	input  logic [mbps_pkg::LEN_IDX_W-1:0]         len_idx,
	output logic                                   hit
);
	import mbps_pkg::*;

	logic [PAT_CAP-1:0] hit_d;
	logic [PAT_CAP-1:0] hit_q;
	logic [PAT_CAP-1:0] prev;

	// Cell zero always starts a fresh prefix; a first byte drops older prefixes.
	always_comb begin
		prev[0] = 1'b1;
		for (int j = 1; j < PAT_CAP; j++) begin
			prev[j] = hit_q[j-1] & ~step.first;
		end
	end

	for (genvar j = 0; j < PAT_CAP; j++) begin : g_cell
		mbps_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (step.en),
			.prev      (prev[j]),
			.care      (care[j]),
			.data_byte (data_byte),
			.pat_byte  (pattern[8*j +: 8]),
			.hit_d     (hit_d[j]),
			.hit_q     (hit_q[j])
		);
	end

	assign hit = hit_d[len_idx];

endmodule

>>> rtl/core/mbps_out_fifo.sv
// Small result queue that decouples the output stream from the scan row.
module mbps_out_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  mbps_pkg::result_t                   push_data,
	input  logic                                pop,
	output logic                                not_empty,
	output mbps_pkg::result_t                   head,
	output logic [mbps_pkg::FIFO_LVL_W-1:0]     level
);
	import mbps_pkg::*;

	result_t               mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_LVL_W-1:0] level_q;
	logic                  do_pop;

	assign do_pop    = pop & (level_q != '0);
	assign not_empty = (level_q != '0);
	assign head      = mem[rd_ptr_q];
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			level_q <= level_q + FIFO_LVL_W'(push) - FIFO_LVL_W'(do_pop);
		end
	end

endmodule

>>> rtl/core/masked_byte_pattern_scanner.sv
// Top level of the masked byte pattern scanner.
//
// Input stream (s_axis_*): one byte per beat. tuser marks the first byte of a
// region and restarts the scan; tlast marks the final byte of the region.
// Output stream (m_axis_*): at most one beat per region. tuser is the found
// flag; tdata is base_address plus the offset of the match start, or zero
// when the region ended without a match. Bytes after a result are dropped
// until the next first byte.
// Configuration: cfg_we writes cfg_data into the register chosen by
// cfg_index (base, pattern low, pattern high, care mask, length); unused
// indexes are ignored. Write only while the block is idle.
// Throughput: one byte per cycle while s_axis_tready is high. Each cell of the row compares the new byte
// against its pattern position and extends its neighbor's prefix match in
// the same cycle, so any byte can follow the previous one directly.
// Result path: the row compare is registered into the result stage, then the
// address add is written into the result queue that drives m_axis.
// Stalls: results wait in a four-entry queue; s_axis_tready drops only when
// the queue plus the in-flight result could fill it.
// Reset: config returns to its defaults (care mask all ones, length one),
// the row clears and the scanner idles until a first byte arrives.
module masked_byte_pattern_scanner (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data,
	// byte stream in
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,  // [7:0] data_byte
	input  logic                                s_axis_tuser,  // [0] first_byte
	input  logic                                s_axis_tlast,  // last_byte
	// result stream out
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [63:0]                         m_axis_tdata,  // [63:0] match_address
	output logic                                m_axis_tuser   // [0] found
);
	import mbps_pkg::*;

	localparam logic [LEN_W-1:0]   CAP_LEN   = LEN_W'(PAT_CAP);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// configuration registers
	logic [ADDR_W-1:0] base_q;
	logic [63:0]       pat_low_q;
	logic [63:0]       pat_high_q;
	logic [15:0]       care_q;
	logic [LEN_W-1:0]  length_q;

	// scan control
	logic               done_q;
	logic [COUNT_W-1:0] seen_q;

	// stage 1: result decided, offset known
	logic               res_v_s1;
	logic               found_s1;
	logic [COUNT_W-1:0] offset_s1;

	logic               accept;
	logic               active;
	logic               hit;
	logic               emit;
	logic [LEN_W-1:0]   len_eff;
	logic [COUNT_W-1:0] seen_next;
	logic [127:0]       pat_all;
	step_t              step;
	result_t            push_data;
	result_t            head;
	logic               not_empty;
	logic [FIFO_LVL_W-1:0] level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= '0;
			pat_low_q  <= '0;
			pat_high_q <= '0;
			care_q     <= '1;
			length_q   <= LEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BASE_ADDRESS:   base_q     <= cfg_data;
				REG_PATTERN_LOW:    pat_low_q  <= cfg_data;
				REG_PATTERN_HIGH:   pat_high_q <= cfg_data;
				REG_CARE_MASK:      care_q     <= cfg_data[15:0];
				REG_PATTERN_LENGTH: length_q   <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp length into one..capacity.
	always_comb begin
		if (length_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (length_q > CAP_LEN) begin
			len_eff = CAP_LEN;
		end else begin
			len_eff = length_q;
		end
	end

	// Hold input while the queue plus the in-flight result could fill it.
	assign s_axis_tready = ({1'b0, level} + {{FIFO_LVL_W{1'b0}}, res_v_s1})
		< (FIFO_LVL_W + 1)'(FIFO_DEPTH);
	assign accept = s_axis_tvalid & s_axis_tready;
	// Drop bytes while idle unless one opens a region.
	assign active = accept & (s_axis_tuser | ~done_q);

	assign step.en    = active;
	assign step.first = s_axis_tuser;
	assign pat_all    = {pat_high_q, pat_low_q};

	mbps_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (s_axis_tdata),
		.pattern   (pat_all[8*PAT_CAP-1:0]),
		.care      (care_q[PAT_CAP-1:0]),
		.len_idx   (LEN_IDX_W'(len_eff - LEN_W'(1))),
		.hit       (hit)
	);

	// Byte count saturates; a first byte restarts it at one.
	always_comb begin
		if (s_axis_tuser) begin
			seen_next = COUNT_W'(1);
		end else if (seen_q == COUNT_MAX) begin
			seen_next = seen_q;
		end else begin
			seen_next = seen_q + COUNT_W'(1);
		end
	end

	assign emit = active & (hit | s_axis_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b1;
			seen_q   <= '0;
			res_v_s1 <= 1'b0;
		end else begin
			res_v_s1 <= emit;
			if (active) begin
				done_q <= emit;
				seen_q <= seen_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			found_s1  <= hit;
			offset_s1 <= seen_next - COUNT_W'(len_eff);
		end
	end

	// Stage 2: add the base and queue the result.
	assign push_data.found = found_s1;
	assign push_data.addr  = found_s1 ? (base_q + ADDR_W'(offset_s1)) : '0;

	mbps_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_v_s1),
		.push_data (push_data),
		.pop       (m_axis_tready),
		.not_empty (not_empty),
		.head      (head),
		.level     (level)
	);

	assign m_axis_tvalid = not_empty;
	assign m_axis_tdata  = head.addr;
	assign m_axis_tuser  = head.found;

endmodule

>>> rtl/core/mbps_checker.sv
// Port-level assertions for the masked byte pattern scanner, bound to the top level.
module mbps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// A not-found result always carries a zero address.
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 64'd0)
		else $error("not-found result with nonzero address");

	// Input backpressure only comes from results piling up at the output.
	a_ready_needs_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no pending result");

	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat withdrawn while stalled");

	a_out_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

>>> tb/scan_result_checker.sv
// Result predictor and comparator for the masked byte pattern scanner.
`timescale 1ns / 100ps

module scan_result_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,
	input  logic                            s_axis_tuser,
	input  logic                            s_axis_tlast,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [63:0]                     m_axis_tdata,
	input  logic                            m_axis_tuser,
	output int                              outstanding,
	output int                              fail_count
);
	import mbps_pkg::*;

	// mirrored registers
	logic [ADDR_W-1:0]  base_q;
	logic [127:0]       pattern_q;
	logic [15:0]        mask_q;
	logic [LEN_W-1:0]   length_q;

	// predicted scanner state
	logic [PATTERN_MAX-1:0][7:0] history;
	logic [COUNT_W-1:0]          offset_count;
	logic                        waiting_first;

	result_t predicted_results[$];
	int      errors;

	function automatic logic [COUNT_W-1:0] active_length();
		if (length_q == '0)
			return COUNT_W'(1);
		if (length_q > PAT_CAP)
			return COUNT_W'(PAT_CAP);
		return COUNT_W'(length_q);
	endfunction

	function automatic bit window_hit(input logic [COUNT_W-1:0] len);
		for (int j = 0; j < len; j++) begin
			if (mask_q[j] && history[len - 1 - j] != pattern_q[8*j +: 8])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Advance the scan by one byte; return one when the byte yields a result.
	function automatic bit scan_byte(input logic [7:0] b, input logic first_flag,
	                                 input logic last_flag, output result_t r);
		logic [COUNT_W-1:0] len;
		len = active_length();
		r = '0;
		if (first_flag) begin
			history = '0;
			offset_count = '0;
			waiting_first = 1'b0;
		end
		if (waiting_first)
			return 1'b0;
		history = {history[PATTERN_MAX-2:0], b};
		if (offset_count != '1)
			offset_count = offset_count + 1'b1;
		if (offset_count >= len && window_hit(len)) begin
			r.found = 1'b1;
			r.addr = base_q + ADDR_W'(offset_count - len);
			waiting_first = 1'b1;
			return 1'b1;
		end
		if (last_flag) begin
			waiting_first = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t r;
		result_t want;
		if (!arst_n) begin
			base_q = '0;
			pattern_q = '0;
			mask_q = 16'hFFFF;
			length_q = LEN_W'(1);
			history = '0;
			offset_count = '0;
			waiting_first = 1'b1;
			predicted_results.delete();
			errors = 0;
			outstanding <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BASE_ADDRESS:   base_q = cfg_data;
					REG_PATTERN_LOW:    pattern_q[63:0] = cfg_data;
					REG_PATTERN_HIGH:   pattern_q[127:64] = cfg_data;
					REG_CARE_MASK:      mask_q = cfg_data[15:0];
					REG_PATTERN_LENGTH: length_q = cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (scan_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast, r))
					predicted_results = {predicted_results, r};
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (predicted_results.size() == 0) begin
					$display("%0t unexpected result: found %0b address %h",
					         $time, m_axis_tuser, m_axis_tdata);
					errors++;
				end else begin
					want = predicted_results.pop_front();
					if (m_axis_tuser !== want.found || m_axis_tdata !== want.addr) begin
						$display("%0t mismatch: expected found %0b address %h,",
						         $time, want.found, want.addr,
						         " actual found %0b address %h",
						         m_axis_tuser, m_axis_tdata);
						errors++;
					end
				end
			end
			outstanding <= predicted_results.size();
			fail_count <= errors;
		end
	end

endmodule

>>> tb/tb.sv
// Stimulus and verdict for the masked byte pattern scanner.
`timescale 1ns / 100ps

module tb;
	import mbps_pkg::*;

	localparam int          CYCLE_LIMIT   = 300000;
	localparam int          DRAIN_CYCLES  = 8;   // margin beyond the result stage and result queue
	localparam int          PHASES        = 4;
	localparam int          SETTINGS_EACH = 3;
	localparam int          BYTES_EACH    = 86;
	localparam logic [7:0]  WILDCARD_CHAR = 8'h3F;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;   // [7:0] data_byte
	logic                  s_axis_tuser;   // [0] first_byte
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [63:0]           m_axis_tdata;   // [63:0] match_address
	logic                  m_axis_tuser;   // [0] found

	int outstanding;
	int fail_count;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int sent;

	// stimulus-side view of the current pattern
	logic [15:0][7:0] pat_bytes;
	logic [15:0]      care;
	int               eff_len;

	masked_byte_pattern_scanner u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	scan_result_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.outstanding   (outstanding),
		.fail_count    (fail_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stall the result side at the rate of the current phase.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Abort a hung run.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// Favor bytes that collide with patterns: zero, all ones and the '?' char.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(3))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return WILDCARD_CHAR;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] noise_byte();
		if ($urandom_range(1))
			return pat_bytes[$urandom_range(15)];
		return pick_byte();
	endfunction

	// Present one beat; hold it until the block takes it.
	task automatic push_byte(input logic [7:0] b, input logic first_flag, input logic last_flag);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= first_flag;
		s_axis_tlast  <= last_flag;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Stop sending and wait until every predicted result has been taken.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// Drain, then write every register plus one unused index.
	task automatic load_settings(input logic [63:0] base, input logic [63:0] plow,
	                             input logic [63:0] phigh, input logic [63:0] mask_word,
	                             input logic [63:0] len_word);
		logic [LEN_W-1:0] raw;
		wait_idle();
		write_reg(REG_BASE_ADDRESS, base);
		write_reg(REG_PATTERN_LOW, plow);
		write_reg(REG_PATTERN_HIGH, phigh);
		write_reg(REG_CARE_MASK, mask_word);
		write_reg(REG_PATTERN_LENGTH, len_word);
		write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, int'(REG_PATTERN_LENGTH) + 1)),
		          {$urandom, $urandom});
		cfg_we <= 1'b0;
		raw = len_word[LEN_W-1:0];
		pat_bytes = {phigh, plow};
		care = mask_word[15:0];
		eff_len = (raw == 0) ? 1 : ((raw > PAT_CAP) ? PAT_CAP : int'(raw));
	endtask

	// One region: mostly with the pattern planted, now and then left open
	// or followed by stray bytes that carry no first flag.
	task automatic run_region();
		int       n;
		int       at;
		bit       closed;
		logic [7:0] b;
		n = $urandom_range(1, 24);
		at = -1;
		if ($urandom_range(99) < 70) begin
			if (n < eff_len)
				n = eff_len + $urandom_range(0, 4);
			at = ($urandom_range(9) == 0) ? n - eff_len : $urandom_range(0, n - eff_len);
		end
		closed = ($urandom_range(19) != 0);
		for (int i = 0; i < n; i++) begin
			if (at >= 0 && i >= at && i < at + eff_len)
				b = care[i - at] ? pat_bytes[i - at] : pick_byte();
			else
				b = noise_byte();
			push_byte(b, i == 0, closed && i == n - 1);
		end
		sent += n;
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 3)) push_byte(noise_byte(), 1'b0, 1'($urandom_range(1)));
		end
	endtask

	initial begin
		int               idle_tab[PHASES];
		int               stall_tab[PHASES];
		logic [63:0]      base;
		logic [63:0]      plow;
		logic [63:0]      phigh;
		logic [63:0]      mask_word;
		logic [63:0]      len_word;

		idle_tab  = '{0, 84, 0, 34};
		stall_tab = '{0, 0, 84, 34};
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		s_axis_tlast  <= 1'b0;
		pat_bytes = '0;
		care = 16'hFFFF;
		eff_len = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: zero base, pattern of one zero byte.
		// Idle stream before any first byte, last flag included: dropped.
		push_byte(8'h00, 1'b0, 1'b1);
		push_byte(8'hFF, 1'b0, 1'b0);
		// Match at offset one, then trailing bytes are dropped.
		push_byte(8'h55, 1'b1, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b1);
		// One-byte regions: hit, then miss.
		push_byte(8'h00, 1'b1, 1'b1);
		push_byte(8'hFF, 1'b1, 1'b1);

		// Four positions, 'A' '?' wildcard 'D'; base all ones so the address wraps.
		load_settings(64'hFFFF_FFFF_FFFF_FFFF, {32'h0, 8'h44, 8'h00, WILDCARD_CHAR, 8'h41},
		              64'h0, 64'hDEAD_BEEF_0000_FFFB, 64'hFFFF_FFFF_FFFF_FFE4);
		// Near miss: the '?' position must match literally.
		push_byte(8'h41, 1'b1, 1'b0);
		push_byte(8'h3E, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'h44, 1'b0, 1'b1);
		// Match that ends on the last byte.
		push_byte(8'h11, 1'b1, 1'b0);
		push_byte(8'h41, 1'b0, 1'b0);
		push_byte(WILDCARD_CHAR, 1'b0, 1'b0);
		push_byte(8'h99, 1'b0, 1'b0);
		push_byte(8'h44, 1'b0, 1'b1);

		// Length zero acts as one; all wildcards hit at once.
		load_settings(64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
		              64'h0000_0000_FFFF_0000, 64'h0000_0000_0000_0020);
		push_byte(8'hAA, 1'b1, 1'b0);
		push_byte(8'hBB, 1'b0, 1'b1);

		// Random part: per phase, one extreme setting and two random ones.
		for (int p = 0; p < PHASES; p++) begin
			for (int s = 0; s < SETTINGS_EACH; s++) begin
				base = {$urandom, $urandom};
				plow = '0;
				phigh = '0;
				for (int j = 0; j < 8; j++) begin
					plow[8*j +: 8]  = pick_byte();
					phigh[8*j +: 8] = pick_byte();
				end
				mask_word = {$urandom, $urandom};
				len_word = {$urandom, $urandom};
				if ($urandom_range(9) == 0)
					len_word[LEN_W-1:0] = LEN_W'($urandom_range(0, 31));
				else
					len_word[LEN_W-1:0] = LEN_W'($urandom_range(1, 16));
				if (s == 0) begin
					case (p)
						0: begin
							base = '1;
							mask_word[15:0] = 16'hFFFF;
							len_word[LEN_W-1:0] = LEN_W'(16);
						end
						1: begin
							base = '0;
							mask_word[15:0] = 16'h0000;
							len_word[LEN_W-1:0] = LEN_W'(0);
						end
						2: begin
							mask_word[15:0] = 16'h8001;
							len_word[LEN_W-1:0] = LEN_W'(31);
						end
						default: begin
							base = 64'hFFFF_FFFF_FFFF_FFFC;
							mask_word[15:0] = 16'hFFFF;
							len_word[LEN_W-1:0] = LEN_W'(1);
						end
					endcase
				end
				load_settings(base, plow, phigh, mask_word, len_word);
				// Switch the idle and stall rates only once the block has gone quiet.
				idle_pct = idle_tab[p];
				stall_pct = stall_tab[p];
				sent = 0;
				while (sent < BYTES_EACH)
					run_region();
			end
		end

		wait_idle();
		if (fail_count == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
